// ===== hdl/r2a_pkg.sv =====
// Shared types and color codes for the RGB12 to ANSI16 quantizer.
package r2a_pkg;

	localparam int unsigned LevelW = 4;
	localparam int unsigned CodeW  = 4;

	localparam logic [CodeW-1:0] ANSI_BLACK   = 4'h0;
	localparam logic [CodeW-1:0] ANSI_RED     = 4'h1;
	localparam logic [CodeW-1:0] ANSI_GREEN   = 4'h2;
	localparam logic [CodeW-1:0] ANSI_YELLOW  = 4'h3;
	localparam logic [CodeW-1:0] ANSI_BLUE    = 4'h4;
	localparam logic [CodeW-1:0] ANSI_MAGENTA = 4'h5;
	localparam logic [CodeW-1:0] ANSI_CYAN    = 4'h6;
	localparam logic [CodeW-1:0] ANSI_SILVER  = 4'h7;
	localparam logic [CodeW-1:0] ANSI_GRAY    = 4'h8;
	localparam logic [CodeW-1:0] ANSI_WHITE   = 4'hF;
	localparam logic [CodeW-1:0] ANSI_BRIGHT  = 4'h8;

	// Level thresholds
	localparam logic [LevelW-1:0] GREY_WHITE_TH  = 4'hC;
	localparam logic [LevelW-1:0] GREY_SILVER_TH = 4'h8;
	localparam logic [LevelW-1:0] GREY_GRAY_TH   = 4'h4;
	localparam logic [LevelW-1:0] SILVER_TH      = 4'd7;
	localparam logic [LevelW-1:0] BRIGHT_TH      = 4'd9;

	typedef struct packed {
		logic              color_valid;
		logic [LevelW-1:0] red;
		logic [LevelW-1:0] green;
		logic [LevelW-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [CodeW-1:0] ansi_code;
		logic             no_color;
	} result_t;

endpackage

// ===== hdl/r2a_quant.sv =====
// Combinational color classifier: grey levels, saturation test, hue sector.
module r2a_quant import r2a_pkg::*; (
	input  pixel_t  pix,
	output result_t res
);

	logic [LevelW-1:0] cmax, cmin, d;
	logic [7:0]        sat_l, sat_r;
	logic signed [8:0] hn_raw, hn;
	logic [8:0]        h2, d9;
	logic [CodeW-1:0]  hue_code, code;

	always_comb begin
		cmax = pix.red;
		if (pix.green > cmax) cmax = pix.green;
		if (pix.blue > cmax) cmax = pix.blue;
		cmin = pix.red;
		if (pix.green < cmin) cmin = pix.green;
		if (pix.blue < cmin) cmin = pix.blue;
		d = cmax - cmin;
	end

	// sat >= 0.3  <=>  10*d >= 3*max
	assign sat_l = 8'({4'b0, d} * 8'd10);
	assign sat_r = 8'({4'b0, cmax} * 8'd3);

	// hn/d is the hue in [0,6); red wins max ties, then green
	assign d9 = {5'b0, d};
	always_comb begin
		if (pix.red == cmax) begin
			hn_raw = $signed({5'b0, pix.green}) - $signed({5'b0, pix.blue});
		end else if (pix.green == cmax) begin
			hn_raw = $signed({5'b0, pix.blue}) - $signed({5'b0, pix.red})
				+ $signed(9'(d9 << 1));
		end else begin
			hn_raw = $signed({5'b0, pix.red}) - $signed({5'b0, pix.green})
				+ $signed(9'(d9 << 2));
		end
		if (hn_raw < 0) hn = hn_raw + $signed(9'(d9 * 9'd6));
		else hn = hn_raw;
	end

	// sector edges go to the lower sector
	assign h2 = {hn[7:0], 1'b0};
	always_comb begin
		if (h2 <= d9) hue_code = ANSI_RED;
		else if (h2 <= 9'(d9 * 9'd3)) hue_code = ANSI_YELLOW;
		else if (h2 <= 9'(d9 * 9'd5)) hue_code = ANSI_GREEN;
		else if (h2 <= 9'(d9 * 9'd7)) hue_code = ANSI_CYAN;
		else if (h2 <= 9'(d9 * 9'd9)) hue_code = ANSI_BLUE;
		else if (h2 <= 9'(d9 * 9'd11)) hue_code = ANSI_MAGENTA;
		else hue_code = ANSI_RED;
	end

	always_comb begin
		if (d != '0) begin
			if (sat_l >= sat_r) code = hue_code;
			else if (cmax > SILVER_TH) code = ANSI_SILVER;
			else code = ANSI_BLACK;
			if (cmax > BRIGHT_TH) code = code | ANSI_BRIGHT;
		end else begin
			if (cmax > GREY_WHITE_TH) code = ANSI_WHITE;
			else if (cmax > GREY_SILVER_TH) code = ANSI_SILVER;
			else if (cmax > GREY_GRAY_TH) code = ANSI_GRAY;
			else code = ANSI_BLACK;
		end
		if (!pix.color_valid) begin
			res.ansi_code = ANSI_BLACK;
			res.no_color  = 1'b1;
		end else begin
			res.ansi_code = code;
			res.no_color  = 1'b0;
		end
	end

endmodule

// ===== hdl/rgb12_to_ansi16_quantizer.sv =====
// Top level: input register, color classifier, result register.
// A beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle; both stages advance whenever the result is taken.
// The input register and result register each hold one beat, so a new beat is
// accepted while a finished result waits for out_ready, if stage 1 is empty.
// Reset (arst_n low, asynchronous) empties both stages; payload is not cleared.
module rgb12_to_ansi16_quantizer import r2a_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              color_valid,
	input  logic [LevelW-1:0] red_level,
	input  logic [LevelW-1:0] green_level,
	input  logic [LevelW-1:0] blue_level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CodeW-1:0]  ansi_code,
	output logic              no_color
);

	pixel_t  pix_s1;
	logic    vld_s1;
	result_t res_c;
	result_t res_s2;
	logic    vld_s2;
	logic    adv_s1, adv_s2;

	// a stage moves when the one after it is empty or draining
	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: input capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pix_s1 <= '{color_valid: color_valid, red: red_level,
				green: green_level, blue: blue_level};
		end
	end

	r2a_quant u_quant (
		.pix(pix_s1),
		.res(res_c)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid = vld_s2;
	assign ansi_code = res_s2.ansi_code;
	assign no_color  = res_s2.no_color;

endmodule

// ===== hdl/r2a_checker.sv =====
// Port-level checks for the quantizer, bound to the top level.
module r2a_checker import r2a_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              color_valid,
	input logic [LevelW-1:0] red_level,
	input logic [LevelW-1:0] green_level,
	input logic [LevelW-1:0] blue_level,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CodeW-1:0]  ansi_code,
	input logic              no_color
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ansi_code) && $stable(no_color))
		else $error("stalled result changed");

	// no-color beat carries a zero code
	a_nocolor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_color |-> ansi_code == ANSI_BLACK)
		else $error("no_color with nonzero code");

	// undefined color comes out as a no-color result when the sink keeps taking
	a_nocolor_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !color_valid) ##1 out_ready |=> out_valid && no_color)
		else $error("no-color beat lost or late");

	// bright grey maps to white
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && color_valid && red_level == green_level
			&& green_level == blue_level && red_level > GREY_WHITE_TH) ##1 out_ready
		|=> out_valid && !no_color && ansi_code == ANSI_WHITE)
		else $error("bright grey not white");

endmodule

bind rgb12_to_ansi16_quantizer r2a_checker u_r2a_checker (.*);
